// ----- design/csrspmv_pkg.sv -----
// shared types and constants for the compressed-row sparse matrix-vector core
package csrspmv_pkg;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_NONZERO = 2'd1;
    localparam logic [1:0] CMD_EMPTY   = 2'd2;

    localparam logic [1:0] REG_ACC_MODE  = 2'd0;
    localparam logic [1:0] REG_COL_COUNT = 2'd1;
    localparam logic [1:0] REG_ROW_COUNT = 2'd2;

    localparam int ACC_W  = 64;
    localparam int FRAC_W = 16;
    localparam int ROW_W  = 16;
    localparam int COL_W  = 11;
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;

    // one row-bearing item with its product, ready to accumulate
    typedef struct packed {
        logic                     valid;
        logic                     bad;
        logic                     row_end;
        logic [DATA_W-1:0]        prior;
        logic signed [ACC_W-1:0]  prod;
    } term_t;

    // a closed row, before rounding
    typedef struct packed {
        logic                     valid;
        logic signed [ACC_W-1:0]  acc;
        logic                     bad;
        logic                     sat;
        logic [ROW_W-1:0]         row_number;
        logic                     last;
    } row_t;

endpackage

// ----- design/csr_sparse_matrix_vector_multiply_core.sv -----
// Sparse matrix times dense vector over compressed rows, Q16.16 values. Load
// items fill the dense vector store; nonzero items multiply their value with
// the stored element of their column and add it to a saturating 64-bit row
// sum; an empty-row item or a nonzero marked row end closes the row and one
// result leaves with the sum rounded and saturated. The block takes one item
// per clock cycle unless the output stalls; a closing item passes in order
// through the vector read, the multiply, the accumulate and the rounding
// stage, each registered. The whole pipeline holds while a result waits at the
// output. The vector store is a single memory of VECTOR_DEPTH entries whose
// contents are undefined until loaded; no clearing pass runs after reset.
module csr_sparse_matrix_vector_multiply_core
    import csrspmv_pkg::*;
#(
    parameter int VECTOR_DEPTH = 1024,
    parameter int VALUE_WIDTH  = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // index[9:0], value[41:10], prior[73:42], zeros
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    input  logic        s_axis_tlast,   // row_end
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // row_result[31:0], row_number[47:32]
    output logic [1:0]  m_axis_tuser,   // bad_column[0], saturated[1]
    output logic        m_axis_tlast    // last_row
);

    localparam int AW = $clog2(VECTOR_DEPTH);
    localparam int XW = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int RW = ACC_W - FRAC_W + 1;
    localparam logic signed [RW-1:0] OUT_MAX = RW'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] OUT_MIN = RW'(-(64'sd1 <<< (VALUE_WIDTH - 1)));

    // configuration registers
    logic              acc_mode_reg;
    logic [COL_W-1:0]  col_count_reg;
    logic [ROW_W-1:0]  row_count_reg;

    logic                     adv;
    logic                     accept;
    logic [1:0]               in_cmd;
    logic [IDX_W-1:0]         in_index;
    logic [DATA_W-1:0]        in_value;
    logic [DATA_W-1:0]        in_prior;
    logic [XW-1:0]            idx_ext;
    logic                     in_store;
    logic [AW-1:0]            addr;
    logic                     in_bad;

    logic [VALUE_WIDTH-1:0]   vec_mem [VECTOR_DEPTH];
    logic [VALUE_WIDTH-1:0]   rd_data_reg;

    // read stage
    logic                     v1_reg;
    logic                     nz1_reg;
    logic                     bad1_reg;
    logic                     end1_reg;
    logic [DATA_W-1:0]        val1_reg;
    logic [DATA_W-1:0]        prior1_reg;

    logic signed [VALUE_WIDTH-1:0]   mul_a;
    logic signed [VALUE_WIDTH-1:0]   mul_b;
    logic signed [2*VALUE_WIDTH-1:0] mul_p;

    term_t                    term_reg;
    row_t                     row;

    // output stage
    logic signed [RW-1:0]     rounded;
    logic signed [RW-1:0]     clamped;
    logic                     out_sat;
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        out_result_reg;
    logic [ROW_W-1:0]         out_row_reg;
    logic                     out_last_reg;
    logic                     out_bad_reg;
    logic                     out_sat_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    assign in_cmd   = s_axis_tuser;
    assign in_index = s_axis_tdata[9:0];
    assign in_value = s_axis_tdata[41:10];
    assign in_prior = s_axis_tdata[73:42];
    assign idx_ext  = XW'(in_index);
    assign in_store = idx_ext < XW'(VECTOR_DEPTH);
    assign addr     = idx_ext[AW-1:0];
    assign in_bad   = (COL_W'(in_index) >= col_count_reg) || !in_store;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_mode_reg  <= 1'b0;
            col_count_reg <= COL_W'(1024);
            row_count_reg <= ROW_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACC_MODE:  acc_mode_reg  <= cfg_data[0];
                REG_COL_COUNT: col_count_reg <= cfg_data[COL_W-1:0];
                REG_ROW_COUNT: row_count_reg <= cfg_data[ROW_W-1:0];
                default:       ;
            endcase
        end
    end

    // vector store: loads write, every other item reads its column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (in_cmd == CMD_LOAD)
            begin
                if (in_store)
                begin
                    vec_mem[addr] <= in_value[VALUE_WIDTH-1:0];
                end
            end
            else
            begin
                rd_data_reg <= vec_mem[addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= accept && (in_cmd == CMD_NONZERO || in_cmd == CMD_EMPTY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nz1_reg    <= in_cmd == CMD_NONZERO;
            bad1_reg   <= (in_cmd == CMD_NONZERO) && in_bad;
            end1_reg   <= (in_cmd == CMD_EMPTY) || s_axis_tlast;
            val1_reg   <= in_value;
            prior1_reg <= in_prior;
        end
    end

    // multiply stage
    always_comb
    begin
        mul_a = val1_reg[VALUE_WIDTH-1:0];
        mul_b = rd_data_reg;
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg <= '0;
        end
        else if (adv)
        begin
            term_reg.valid   <= v1_reg;
            term_reg.bad     <= bad1_reg;
            term_reg.row_end <= end1_reg;
            term_reg.prior   <= prior1_reg;
            term_reg.prod    <= (nz1_reg && !bad1_reg) ? ACC_W'(mul_p) : '0;
        end
    end

    csrspmv_accum #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .accumulate_mode (acc_mode_reg),
        .row_count       (row_count_reg),
        .term            (term_reg),
        .row             (row)
    );

    // round to nearest with ties up, then clamp to the value range
    always_comb
    begin
        rounded = RW'(row.acc >>> FRAC_W) + RW'(row.acc[FRAC_W-1]);
        out_sat = 1'b0;
        if (rounded > OUT_MAX)
        begin
            clamped = OUT_MAX;
            out_sat = 1'b1;
        end
        else if (rounded < OUT_MIN)
        begin
            clamped = OUT_MIN;
            out_sat = 1'b1;
        end
        else
        begin
            clamped = rounded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= row.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_result_reg <= clamped[DATA_W-1:0];
            out_row_reg    <= row.row_number;
            out_last_reg   <= row.last;
            out_bad_reg    <= row.bad;
            out_sat_reg    <= row.sat | out_sat;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_row_reg, out_result_reg};
    assign m_axis_tuser  = {out_sat_reg, out_bad_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- design/csrspmv_accum.sv -----
// row accumulator: saturating 64-bit sum of products and row bookkeeping
module csrspmv_accum
    import csrspmv_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             accumulate_mode,
    input  logic [ROW_W-1:0] row_count,
    input  term_t            term,
    output row_t             row
);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic signed [ACC_W-1:0] acc_reg;
    logic                    started_reg;
    logic                    bad_reg;
    logic                    sat_reg;
    logic [ROW_W-1:0]        row_counter_reg;
    row_t                    row_reg;

    logic signed [VALUE_WIDTH-1:0] prior_v;
    logic signed [ACC_W-1:0]       prior_ext;
    logic signed [ACC_W-1:0]       base;
    logic signed [ACC_W:0]         wide_sum;
    logic signed [ACC_W-1:0]       sum;
    logic                          ovf;
    logic                          bad_next;
    logic                          sat_next;
    logic                          last;

    always_comb
    begin
        prior_v   = term.prior[VALUE_WIDTH-1:0];
        prior_ext = ACC_W'(prior_v);
        // a new row starts from zero or from the prior value in Q32.32
        if (started_reg)
        begin
            base = acc_reg;
        end
        else if (accumulate_mode)
        begin
            base = prior_ext <<< FRAC_W;
        end
        else
        begin
            base = '0;
        end
        wide_sum = (ACC_W+1)'(base) + (ACC_W+1)'(term.prod);
        ovf      = wide_sum[ACC_W] != wide_sum[ACC_W-1];
        if (ovf)
        begin
            sum = wide_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            sum = wide_sum[ACC_W-1:0];
        end
        bad_next = (started_reg & bad_reg) | term.bad;
        sat_next = (started_reg & sat_reg) | ovf;
        last     = row_counter_reg == (row_count - ROW_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg         <= '0;
            started_reg     <= 1'b0;
            bad_reg         <= 1'b0;
            sat_reg         <= 1'b0;
            row_counter_reg <= '0;
            row_reg         <= '0;
        end
        else if (adv)
        begin
            row_reg.valid      <= term.valid & term.row_end;
            // closed-row payload
            row_reg.acc        <= sum;
            row_reg.bad        <= bad_next;
            row_reg.sat        <= sat_next;
            row_reg.row_number <= row_counter_reg;
            row_reg.last       <= last;
            if (term.valid)
            begin
                if (term.row_end)
                begin
                    acc_reg         <= '0;
                    started_reg     <= 1'b0;
                    bad_reg         <= 1'b0;
                    sat_reg         <= 1'b0;
                    row_counter_reg <= last ? '0 : row_counter_reg + ROW_W'(1);
                end
                else
                begin
                    acc_reg     <= sum;
                    started_reg <= 1'b1;
                    bad_reg     <= bad_next;
                    sat_reg     <= sat_next;
                end
            end
        end
    end

    assign row = row_reg;

endmodule
